### sv/double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Immediate-condition and next-cycle checks, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define DEU_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("deque assertion failed");
// Consequence holds in the cycle after the antecedent.
`define DEU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DEU_ASSERT(lbl, clk, rstn, cond)
`define DEU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/deu_pkg.sv
// ----------------------------------------------------------------------------
// deu_pkg
// Shared constants, operation and status codes, and control structs.
// ----------------------------------------------------------------------------
package deu_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // input transfer: run the operation
        logic rd;     // read the store at the dump pointer
        logic emit;   // load the read value into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;      // queue holds no value
        logic last_elem;  // one dump element left
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

endpackage

### sv/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values on stream channels.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                 tuser                tlast
//  s_axis    in         value_in [31:0]       operation [2:0]      -
//  m_axis    out        value_out [31:0]      status [1:0]         final_result
//
//  Push, pop and unknown operations give one registered result each.
//  A dump is taken on its input transfer; then each stored value is first
//  read from the ring store through its registered read port and then loaded
//  into the output register. A dump of an empty queue gives one result.
//  Reset empties the queue at once; the store itself is not cleared.
//  A stalled output holds its result and blocks further transfers and dump emits.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
#(
    parameter int QUEUE_DEPTH = deu_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input operations
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic signed [deu_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value_in
    input  logic [deu_pkg::OP_W-1:0]          s_axis_tuser,   // [2:0] operation
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic signed [deu_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] value_out
    output logic [deu_pkg::STATUS_W-1:0]      m_axis_tuser,   // [1:0] status
    output logic                              m_axis_tlast    // final_result
);

    deu_pkg::ctrl_cmd_t  cmd;
    deu_pkg::dp_status_t dp_status;

    // Sequencer: decides when to take a transfer and steps each dump element
    deu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .operation (s_axis_tuser),
        .dp_status (dp_status),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    // Datapath: ring store, indices and the output register that parts
    // the two channels
    deu_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .operation  (s_axis_tuser),
        .value_in   (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .dp_status  (dp_status),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_value  (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

### sv/deu_ctrl.sv
// ----------------------------------------------------------------------------
// deu_ctrl
// Sequencer: accepts operations and steps dumps one element at a time.
// ----------------------------------------------------------------------------
module deu_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [deu_pkg::OP_W-1:0]   operation,
    input  deu_pkg::dp_status_t        dp_status,
    output logic                       in_ready,
    output deu_pkg::ctrl_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       is_dump;

    always_comb
    begin
        is_dump    = operation inside {deu_pkg::OP_DUMP_FWD, deu_pkg::OP_DUMP_BWD};
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = dp_status.out_free;
                if (in_valid && dp_status.out_free)
                begin
                    cmd.exec = 1'b1;
                    if (is_dump && !dp_status.empty)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = dp_status.last_elem ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/deu_dpath.sv
// ----------------------------------------------------------------------------
// deu_dpath
// Ring store, front index, entry count, dump pointer and output register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_assert.svh"

module deu_dpath
#(
    parameter int QUEUE_DEPTH = deu_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  deu_pkg::ctrl_cmd_t            cmd,
    input  logic [deu_pkg::OP_W-1:0]      operation,
    input  logic signed [deu_pkg::DATA_W-1:0] value_in,
    input  logic                          out_ready,
    output deu_pkg::dp_status_t           dp_status,
    output logic                          out_valid,
    output logic [deu_pkg::STATUS_W-1:0]  out_status,
    output logic signed [deu_pkg::DATA_W-1:0] out_value,
    output logic                          out_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic signed [deu_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];
    logic signed [deu_pkg::DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] dptr_reg, dptr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             dir_back_reg, dir_back_next;
    logic             out_valid_reg, out_valid_next;
    logic [deu_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic signed [deu_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    logic             empty, full, out_free, is_push;
    logic [SUM_W-1:0] tail_sum, last_sum;
    logic [IDX_W-1:0] tail_slot, last_slot, front_dec, front_inc;
    logic [IDX_W-1:0] dptr_inc, dptr_dec;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             load_out;

    always_comb
    begin
        empty     = (count_reg == '0);
        full      = (count_reg >= DEPTH_CNT);
        out_free  = !out_valid_reg || out_ready;
        is_push   = (operation == deu_pkg::OP_PUSH_FRONT) ||
                    (operation == deu_pkg::OP_PUSH_BACK);
        tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
        last_sum  = tail_sum - 1'b1;
        tail_slot = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM) : IDX_W'(tail_sum);
        last_slot = (last_sum >= DEPTH_SUM) ? IDX_W'(last_sum - DEPTH_SUM) : IDX_W'(last_sum);
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
        dptr_inc  = (dptr_reg == LAST_IDX) ? '0 : dptr_reg + 1'b1;
        dptr_dec  = (dptr_reg == '0) ? LAST_IDX : dptr_reg - 1'b1;
    end

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        dptr_next       = dptr_reg;
        remain_next     = remain_reg;
        dir_back_next   = dir_back_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_slot;
        load_out        = 1'b0;

        if (cmd.exec)
        begin
            load_out        = 1'b1;
            out_status_next = deu_pkg::STAT_OK;
            out_value_next  = '0;
            out_last_next   = 1'b1;
            case (operation)
                deu_pkg::OP_PUSH_FRONT, deu_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        out_status_next = deu_pkg::STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (operation == deu_pkg::OP_PUSH_FRONT)
                        begin
                            wr_addr    = front_dec;
                            front_next = front_dec;
                        end
                    end
                end
                deu_pkg::OP_POP_FRONT, deu_pkg::OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        out_status_next = deu_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (operation == deu_pkg::OP_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                deu_pkg::OP_DUMP_FWD, deu_pkg::OP_DUMP_BWD:
                begin
                    if (empty)
                    begin
                        out_status_next = deu_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // no result yet: elements follow one by one
                        load_out      = 1'b0;
                        remain_next   = count_reg;
                        dir_back_next = (operation == deu_pkg::OP_DUMP_BWD);
                        dptr_next     = (operation == deu_pkg::OP_DUMP_BWD) ? last_slot
                                                                            : front_reg;
                    end
                end
                default:
                begin
                    out_status_next = deu_pkg::STAT_OK;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            load_out        = 1'b1;
            out_status_next = deu_pkg::STAT_OK;
            out_value_next  = rd_data_reg;
            out_last_next   = (remain_reg == CNT_W'(1));
            remain_next     = remain_reg - 1'b1;
            dptr_next       = dir_back_reg ? dptr_dec : dptr_inc;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_in;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[dptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            dptr_reg      <= '0;
            remain_reg    <= '0;
            dir_back_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            dptr_reg      <= dptr_next;
            remain_reg    <= remain_next;
            dir_back_reg  <= dir_back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign dp_status.empty     = empty;
    assign dp_status.last_elem = (remain_reg == CNT_W'(1));
    assign dp_status.out_free  = out_free;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;

    `DEU_ASSERT(a_count_bound, clk, rst_n, count_reg <= DEPTH_CNT)
    `DEU_ASSERT(a_front_bound, clk, rst_n, front_reg <= LAST_IDX)
    `DEU_ASSERT(a_emit_has_elem, clk, rst_n, !cmd.emit || (remain_reg != '0))
    `DEU_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.exec && is_push && !full, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

### test/double_ended_queue_unit_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_checker
// Watches both stream channels of the deque unit, keeps a shadow copy of the
// ring store, predicts every result of each accepted operation and compares
// each returned result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_checker
#(
    parameter int QUEUE_DEPTH = deu_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic signed [deu_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value_in
    input  logic [deu_pkg::OP_W-1:0]          s_axis_tuser,   // [2:0] operation
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic signed [deu_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] value_out
    input  logic [deu_pkg::STATUS_W-1:0]      m_axis_tuser,   // [1:0] status
    input  logic                              m_axis_tlast,   // final_result
    output int                                errors,
    output int                                due_count
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [deu_pkg::STATUS_W-1:0]      status;
        logic signed [deu_pkg::DATA_W-1:0] value;
        logic                              last;
    } deque_result_t;

    logic signed [deu_pkg::DATA_W-1:0] shadow_ring [QUEUE_DEPTH];
    logic [IDX_W-1:0]                  shadow_head;
    logic [CNT_W-1:0]                  shadow_fill;
    deque_result_t                     awaited_results [$];

    function automatic logic [IDX_W-1:0] ring_slot(input logic [CNT_W-1:0] offset);
        int s;
        s = int'(shadow_head) + int'(offset);
        if (s >= QUEUE_DEPTH)
            s -= QUEUE_DEPTH;
        return IDX_W'(s);
    endfunction

    function automatic deque_result_t make_result(
        input logic [deu_pkg::STATUS_W-1:0]      status,
        input logic signed [deu_pkg::DATA_W-1:0] value,
        input logic                              last);
        deque_result_t r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t deque checker: %s", $time, msg);
        errors++;
    endtask

    // Advance the shadow queue by one operation and queue what it emits.
    task automatic apply_operation(input logic [deu_pkg::OP_W-1:0] op,
                                   input logic signed [deu_pkg::DATA_W-1:0] value_in);
        int               k;
        logic [CNT_W-1:0] off;
        case (op)
            deu_pkg::OP_PUSH_FRONT, deu_pkg::OP_PUSH_BACK:
            begin
                if (int'(shadow_fill) >= QUEUE_DEPTH)
                begin
                    awaited_results.push_back(make_result(deu_pkg::STAT_FULL, '0, 1'b1));
                end
                else
                begin
                    if (op == deu_pkg::OP_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head == '0) ? IDX_W'(QUEUE_DEPTH - 1)
                                                          : shadow_head - 1'b1;
                        shadow_ring[shadow_head] = value_in;
                    end
                    else
                    begin
                        shadow_ring[ring_slot(shadow_fill)] = value_in;
                    end
                    shadow_fill++;
                    awaited_results.push_back(make_result(deu_pkg::STAT_OK, '0, 1'b1));
                end
            end
            deu_pkg::OP_POP_FRONT, deu_pkg::OP_POP_BACK:
            begin
                if (shadow_fill == '0)
                begin
                    awaited_results.push_back(make_result(deu_pkg::STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    if (op == deu_pkg::OP_POP_FRONT)
                        shadow_head = (int'(shadow_head) == QUEUE_DEPTH - 1) ? '0
                                                                             : shadow_head + 1'b1;
                    shadow_fill--;
                    awaited_results.push_back(make_result(deu_pkg::STAT_OK, '0, 1'b1));
                end
            end
            deu_pkg::OP_DUMP_FWD, deu_pkg::OP_DUMP_BWD:
            begin
                if (shadow_fill == '0)
                begin
                    awaited_results.push_back(make_result(deu_pkg::STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    for (k = 0; k < int'(shadow_fill); k++)
                    begin
                        off = (op == deu_pkg::OP_DUMP_FWD) ? CNT_W'(k)
                                                           : CNT_W'(int'(shadow_fill) - 1 - k);
                        awaited_results.push_back(make_result(deu_pkg::STAT_OK,
                                                              shadow_ring[ring_slot(off)],
                                                              k == int'(shadow_fill) - 1));
                    end
                end
            end
            default:
            begin
                awaited_results.push_back(make_result(deu_pkg::STAT_OK, '0, 1'b1));
            end
        endcase
    endtask

    task automatic compare_result();
        deque_result_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                      m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end
        else
        begin
            want = awaited_results.pop_front();
            if (m_axis_tuser !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
            if (m_axis_tdata !== want.value)
                report_mismatch($sformatf("value_out %0d, want %0d", m_axis_tdata, want.value));
            if (m_axis_tlast !== want.last)
                report_mismatch($sformatf("final_result %0b, want %0b",
                                          m_axis_tlast, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_head = '0;
            shadow_fill = '0;
            errors      = 0;
            awaited_results.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_operation(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                compare_result();
        end
        due_count = awaited_results.size();
    end

endmodule

### test/double_ended_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Drives operations into the deque unit, stalls the result side at random
// and leaves all prediction and comparison to the attached checker.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

    // Codes outside the defined operation set; the unit answers them with ok.
    localparam logic [deu_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [deu_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 360;
    localparam int CALM_AFTER   = 300;   // no idling past this many random items
    localparam int DRAIN_CYCLES = 60;    // watch for stray results after the last expected one

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } op_mix_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic signed [deu_pkg::DATA_W-1:0] s_axis_tdata;   // [31:0] value_in
    logic [deu_pkg::OP_W-1:0]          s_axis_tuser;   // [2:0] operation
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic signed [deu_pkg::DATA_W-1:0] m_axis_tdata;   // [31:0] value_out
    logic [deu_pkg::STATUS_W-1:0]      m_axis_tuser;   // [1:0] status
    logic                              m_axis_tlast;   // final_result

    int errors;
    int due_count;
    bit quiet;        // suppress idling on both sides
    int stall_left;

    double_ended_queue_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    double_ended_queue_unit_checker checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .due_count     (due_count)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: hold tready low in short random bursts unless quiet.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Bias toward the edges of the value range so sign and extremes get hit.
    function automatic logic signed [deu_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [deu_pkg::OP_W-1:0] pick_push();
        return $urandom_range(0, 1) ? deu_pkg::OP_PUSH_BACK : deu_pkg::OP_PUSH_FRONT;
    endfunction

    function automatic logic [deu_pkg::OP_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? deu_pkg::OP_POP_BACK : deu_pkg::OP_POP_FRONT;
    endfunction

    function automatic logic [deu_pkg::OP_W-1:0] pick_dump();
        return $urandom_range(0, 1) ? deu_pkg::OP_DUMP_BWD : deu_pkg::OP_DUMP_FWD;
    endfunction

    function automatic logic [deu_pkg::OP_W-1:0] pick_op(input op_mix_t mix);
        int r;
        r = $urandom_range(0, 15);
        case (mix)
            MIX_FILL:  return (r < 13) ? pick_push() : (r < 14) ? pick_pop() : pick_dump();
            MIX_DRAIN: return (r < 13) ? pick_pop() : (r < 14) ? pick_push() : pick_dump();
            default:
            begin
                if (r < 5)
                    return pick_push();
                if (r < 10)
                    return pick_pop();
                if (r < 14)
                    return pick_dump();
                if (r == 14)
                    return pick_pop();
                return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            end
        endcase
    endfunction

    // Present one operation and hold it until the transfer completes.
    task automatic send_op(input logic [deu_pkg::OP_W-1:0] op,
                           input logic signed [deu_pkg::DATA_W-1:0] value);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin
        int      sent;
        int      seg_len;
        int      i;
        op_mix_t mix;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = deu_pkg::OP_PUSH_FRONT;
        quiet         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-queue answers, spare codes, extremes, both dump orders.
        send_op(deu_pkg::OP_DUMP_FWD, 32'sd5);
        send_op(deu_pkg::OP_DUMP_BWD, -32'sd5);
        send_op(deu_pkg::OP_POP_FRONT, '0);
        send_op(deu_pkg::OP_POP_BACK, '0);
        send_op(OP_SPARE_LO, 32'sh7fff_ffff);
        send_op(OP_SPARE_HI, 32'sh8000_0000);
        send_op(deu_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_op(deu_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        send_op(deu_pkg::OP_PUSH_FRONT, -32'sd1);
        send_op(deu_pkg::OP_PUSH_BACK, '0);
        send_op(deu_pkg::OP_PUSH_FRONT, 32'sd1);
        send_op(deu_pkg::OP_DUMP_FWD, '0);
        send_op(deu_pkg::OP_DUMP_BWD, '0);
        send_op(deu_pkg::OP_POP_FRONT, 32'sd9);
        send_op(deu_pkg::OP_POP_BACK, -32'sd9);
        send_op(deu_pkg::OP_DUMP_FWD, '0);
        send_op(deu_pkg::OP_DUMP_BWD, '0);

        // Fill past capacity so refused pushes and full dumps occur, then drain
        // past empty so the ring wraps both ways.
        sent = 0;
        for (i = 0; i < 20; i++)
        begin
            send_op(pick_push(), pick_value());
            sent++;
        end
        send_op(deu_pkg::OP_DUMP_FWD, pick_value());
        send_op(deu_pkg::OP_DUMP_BWD, pick_value());
        sent += 2;
        for (i = 0; i < 20; i++)
        begin
            send_op(pick_pop(), pick_value());
            sent++;
        end

        // Random segments, each leaning toward filling, draining or neither.
        while (sent < RANDOM_ITEMS)
        begin
            mix     = op_mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(10, 30);
            quiet   = (sent >= CALM_AFTER) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < seg_len && sent < RANDOM_ITEMS; i++)
            begin
                send_op(pick_op(mix), pick_value());
                sent++;
                if (sent >= CALM_AFTER)
                    quiet = 1'b1;
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Wait out outstanding results, then watch for stray ones.
        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("double_ended_queue_unit_tb: done, clean");
        else
            $display("double_ended_queue_unit_tb: done, errors");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("double_ended_queue_unit_tb: done, errors");
        $finish;
    end

endmodule
